### sv/ffa_pkg.sv
// Shared types and codes for the first-fit block pool allocator.
`timescale 1ns / 1ps

package ffa_pkg;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_FREE    = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_NOFIT  = 2'd1,
      STATUS_TOOBIG = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_SCAN = 2'd2
   } state_type;

   typedef struct packed {
      logic load;
      logic free_en;
      logic clear_all;
   } ctl_type;

   typedef struct packed {
      logic        valid;
      logic        found;
      logic [31:0] size;
      logic [31:0] addr;
      logic [7:0]  idx;
   } pkt_type;

endpackage

### sv/ffa_cell.sv
// One pool entry: address, size in bytes, used mark and one stage of the search chain.
`timescale 1ns / 1ps

module ffa_cell #(
   parameter int INDEX   = 0,
   parameter int BYTES_W = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  ffa_pkg::ctl_type   ctl,
   input  logic [7:0]         cmd_idx,
   input  logic [31:0]        cmd_addr,
   input  logic [BYTES_W-1:0] cmd_bytes,
   input  logic [8:0]         count,
   input  ffa_pkg::pkt_type   pkt_i,
   output ffa_pkg::pkt_type   pkt_o
);

   localparam logic [7:0] IDX8 = 8'(INDEX);

   logic [31:0]        addr_ff, addr_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic               used_ff, used_in;
   ffa_pkg::pkt_type   pkt_ff, pkt_in;
   logic               in_scope;
   logic               hit;
   logic               fits;

   assign in_scope = int'(count) > INDEX;
   assign hit      = int'(cmd_idx) == INDEX;
   assign fits     = 32'(bytes_ff) >= pkt_i.size;

   always_comb begin
      addr_in  = addr_ff;
      bytes_in = bytes_ff;
      used_in  = used_ff;
      pkt_in   = pkt_i;
      if (ctl.load && hit) begin
         addr_in  = cmd_addr;
         bytes_in = cmd_bytes;
         used_in  = 1'b0;
      end
      if (ctl.free_en && in_scope && addr_ff == cmd_addr) begin
         used_in = 1'b0;
      end
      if (ctl.clear_all) begin
         used_in = 1'b0;
      end
      // grab the travelling request if it is still unserved
      if (pkt_i.valid && !pkt_i.found && in_scope && !used_ff && fits) begin
         used_in      = 1'b1;
         pkt_in.found = 1'b1;
         pkt_in.addr  = addr_ff;
         pkt_in.idx   = IDX8;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      bytes_ff <= bytes_in;
      if (reset) begin
         used_ff <= 1'b0;
         pkt_ff  <= '0;
      end else begin
         used_ff <= used_in;
         pkt_ff  <= pkt_in;
      end
   end

   assign pkt_o = pkt_ff;

endmodule

### sv/first_fit_block_pool_allocator_top.sv
// Top level of the first-fit block pool allocator: command port, control and cell row.
`timescale 1ns / 1ps

// The pool is a row of NUM_BLOCKS cells, one per entry. An item is taken when start is
// high and busy is low; its single result word appears on the rsp_ ports for exactly one
// cycle with rsp_valid high, and cannot be held off. Load, free, release and an oversized
// allocate give their result from the EXEC state alone; busy falls as that result word
// appears, so the next item can then be accepted. A normal allocate walks a request word
// through the whole cell row, one cell per cycle, in the SCAN state, so busy stays high
// until the word leaves the last cell, and the result is registered from that cell's
// output. Only entries below block_count take part in allocate and free. The count
// register is written through csr_ only while the block is idle.
module first_fit_block_pool_allocator_top #(
   parameter int NUM_BLOCKS      = 256,
   parameter int PAGE_BYTES      = 4096,
   parameter int MAX_BLOCK_PAGES = 1999
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_entry_index,
   input  logic [31:0] req_entry_address,
   input  logic [10:0] req_entry_pages,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_granted_address,
   output logic [7:0]  rsp_granted_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);

   localparam longint    MAX_BYTES = longint'(2047) * longint'(PAGE_BYTES);
   localparam int        BYTES_W   = $clog2(MAX_BYTES + 1);
   localparam logic [32:0] LIMIT   = 33'(longint'(MAX_BLOCK_PAGES) * longint'(PAGE_BYTES));

   ffa_pkg::state_type  state_ff, state_in;
   ffa_pkg::op_type     op_ff, op_in;
   logic [7:0]          idx_ff, idx_in;
   logic [31:0]         addr_ff, addr_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [31:0]         size_ff, size_in;
   logic                toobig_ff, toobig_in;
   logic [8:0]          count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ffa_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [31:0]         rsp_addr_ff, rsp_addr_in;
   logic [7:0]          rsp_idx_ff, rsp_idx_in;
   ffa_pkg::ctl_type    ctl;
   ffa_pkg::pkt_type    head_pkt;
   ffa_pkg::pkt_type    chain [NUM_BLOCKS+1];
   logic                accept;

   assign busy      = state_ff != ffa_pkg::S_IDLE;
   assign accept    = start && !busy;
   assign csr_ready = !busy;
   assign chain[0]  = head_pkt;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      addr_in       = addr_ff;
      bytes_in      = bytes_ff;
      size_in       = size_ff;
      toobig_in     = toobig_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ffa_pkg::STATUS_OK;
      rsp_addr_in   = 32'd0;
      rsp_idx_in    = 8'd0;
      ctl           = '0;
      head_pkt      = '0;
      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end
      unique case (state_ff)
         ffa_pkg::S_IDLE: begin
            if (accept) begin
               op_in     = ffa_pkg::op_type'(req_type);
               idx_in    = req_entry_index;
               addr_in   = (ffa_pkg::op_type'(req_type) == ffa_pkg::OP_FREE) ?
                           req_free_address : req_entry_address;
               bytes_in  = BYTES_W'(32'(req_entry_pages) * 32'(PAGE_BYTES));
               size_in   = req_request_size;
               toobig_in = {1'b0, req_request_size} > LIMIT;
               state_in  = ffa_pkg::S_EXEC;
            end
         end
         ffa_pkg::S_EXEC: begin
            ctl.load      = op_ff == ffa_pkg::OP_LOAD;
            ctl.free_en   = op_ff == ffa_pkg::OP_FREE;
            ctl.clear_all = op_ff == ffa_pkg::OP_RELEASE;
            if (op_ff == ffa_pkg::OP_ALLOC && !toobig_ff) begin
               head_pkt.valid = 1'b1;
               head_pkt.size  = size_ff;
               state_in       = ffa_pkg::S_SCAN;
            end else begin
               rsp_valid_in = 1'b1;
               if (op_ff == ffa_pkg::OP_ALLOC) begin
                  rsp_status_in = ffa_pkg::STATUS_TOOBIG;
               end
               state_in = ffa_pkg::S_IDLE;
            end
         end
         ffa_pkg::S_SCAN: begin
            if (chain[NUM_BLOCKS].valid) begin
               rsp_valid_in = 1'b1;
               if (chain[NUM_BLOCKS].found) begin
                  rsp_addr_in = chain[NUM_BLOCKS].addr;
                  rsp_idx_in  = chain[NUM_BLOCKS].idx;
               end else begin
                  rsp_status_in = ffa_pkg::STATUS_NOFIT;
               end
               state_in = ffa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffa_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      addr_ff       <= addr_in;
      bytes_ff      <= bytes_in;
      size_ff       <= size_in;
      toobig_ff     <= toobig_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_idx_ff    <= rsp_idx_in;
      if (reset) begin
         state_ff     <= ffa_pkg::S_IDLE;
         count_ff     <= 9'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
      ffa_cell #(
         .INDEX   (g),
         .BYTES_W (BYTES_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .cmd_idx   (idx_ff),
         .cmd_addr  (addr_ff),
         .cmd_bytes (bytes_ff),
         .count     (count_ff),
         .pkt_i     (chain[g]),
         .pkt_o     (chain[g+1])
      );
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_granted_index   = rsp_idx_ff;

`ifndef SYNTHESIS
   a_idle_chain_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ffa_pkg::S_IDLE |-> !chain[NUM_BLOCKS].valid)
      else $error("request word left the cell row while idle");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ffa_pkg::S_EXEC || state_ff == ffa_pkg::S_SCAN))
      else $error("result word without a command in flight");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ffa_pkg::STATUS_OK |->
         rsp_granted_address == 32'd0 && rsp_granted_index == 8'd0)
      else $error("refused request carries a grant");
`endif

endmodule
